// ----- hw/rtl/dual_sensor_alarm_level_hysteresis_macros.svh -----
// ----------------------------------------------------------------------------
// dual sensor alarm macros
// assertion shorthands used by dsal_level, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef DUAL_SENSOR_ALARM_LEVEL_HYSTERESIS_MACROS_SVH
`define DUAL_SENSOR_ALARM_LEVEL_HYSTERESIS_MACROS_SVH

// same-cycle implication
`define DSAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DSAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/dsal_pkg.sv -----
// ----------------------------------------------------------------------------
// dsal_pkg
// types, register codes and reset values of the dual sensor alarm
// ----------------------------------------------------------------------------
package dsal_pkg;

  localparam int unsigned AqiW  = 9;
  localparam int unsigned Co2W  = 16;
  localparam int unsigned CntW  = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [Co2W:0] Co2CritOffset  = 17'd400;
  localparam logic [Co2W:0] Co2CritClear   = 17'd300;
  localparam logic [Co2W:0] Co2ClearMargin = 17'd100;

  localparam logic [AqiW-1:0] AqiWarnOnRst  = 9'd100;
  localparam logic [AqiW-1:0] AqiWarnOffRst = 9'd90;
  localparam logic [AqiW-1:0] AqiDangOnRst  = 9'd150;
  localparam logic [AqiW-1:0] AqiDangOffRst = 9'd130;
  localparam logic [AqiW-1:0] AqiCritOnRst  = 9'd250;
  localparam logic [AqiW-1:0] AqiCritOffRst = 9'd220;
  localparam logic [Co2W-1:0] Co2WarnRst    = 16'd1000;
  localparam logic [Co2W-1:0] Co2DangRst    = 16'd1500;

  typedef enum logic [1:0] {
    LVL_NONE     = 2'd0,
    LVL_WARNING  = 2'd1,
    LVL_DANGER   = 2'd2,
    LVL_CRITICAL = 2'd3
  } level_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_AQI_WARN_ON   = 3'd0,
    REG_AQI_WARN_OFF  = 3'd1,
    REG_AQI_DANG_ON   = 3'd2,
    REG_AQI_DANG_OFF  = 3'd3,
    REG_AQI_CRIT_ON   = 3'd4,
    REG_AQI_CRIT_OFF  = 3'd5,
    REG_CO2_WARN      = 3'd6,
    REG_CO2_DANG      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [AqiW-1:0] aqi_warn_on;
    logic [AqiW-1:0] aqi_warn_off;
    logic [AqiW-1:0] aqi_dang_on;
    logic [AqiW-1:0] aqi_dang_off;
    logic [AqiW-1:0] aqi_crit_on;
    logic [AqiW-1:0] aqi_crit_off;
    logic [Co2W-1:0] co2_warn;
    logic [Co2W-1:0] co2_dang;
  } thr_t;

  typedef struct packed {
    level_t     cand;
    logic [1:0] reason;
    logic       clr_warning;
    logic       clr_danger;
    logic       clr_critical;
  } grade_t;

endpackage

// ----- hw/rtl/dsal_grade.sv -----
// ----------------------------------------------------------------------------
// dsal_grade
// grades one sample pair against the thresholds and flags which held
// levels may clear
// ----------------------------------------------------------------------------
module dsal_grade import dsal_pkg::*; (
  input  thr_t            thr_i,
  input  logic [AqiW-1:0] aqi_i,
  input  logic [Co2W-1:0] ppm_i,
  output grade_t          grd_o
);

  level_t        ga;
  level_t        gc;
  logic [Co2W:0] ppm_x;
  logic [Co2W:0] warn_x;
  logic [Co2W:0] dang_x;

  assign ppm_x  = {1'b0, ppm_i};
  assign warn_x = {1'b0, thr_i.co2_warn};
  assign dang_x = {1'b0, thr_i.co2_dang};

  always_comb begin
    if (aqi_i >= thr_i.aqi_crit_on) begin
      ga = LVL_CRITICAL;
    end else if (aqi_i >= thr_i.aqi_dang_on) begin
      ga = LVL_DANGER;
    end else if (aqi_i >= thr_i.aqi_warn_on) begin
      ga = LVL_WARNING;
    end else begin
      ga = LVL_NONE;
    end

    if (ppm_x >= dang_x + Co2CritOffset) begin
      gc = LVL_CRITICAL;
    end else if (ppm_x >= dang_x) begin
      gc = LVL_DANGER;
    end else if (ppm_x >= warn_x) begin
      gc = LVL_WARNING;
    end else begin
      gc = LVL_NONE;
    end
  end

  always_comb begin
    grd_o.cand         = (ga > gc) ? ga : gc;
    grd_o.reason       = {gc != LVL_NONE, ga != LVL_NONE};
    // "below x minus 100" kept positive as "plus 100 below x"
    grd_o.clr_warning  = (aqi_i < thr_i.aqi_warn_off) &&
                         (ppm_x + Co2ClearMargin < warn_x);
    grd_o.clr_danger   = (aqi_i < thr_i.aqi_dang_off) &&
                         (ppm_x + Co2ClearMargin < dang_x);
    grd_o.clr_critical = (aqi_i < thr_i.aqi_crit_off) &&
                         (ppm_x < dang_x + Co2CritClear);
  end

endmodule

// ----- hw/rtl/dsal_level.sv -----
// ----------------------------------------------------------------------------
// dsal_level
// held alarm level with hysteresis, activation counter and result register
// ----------------------------------------------------------------------------
`include "dual_sensor_alarm_level_hysteresis_macros.svh"

module dsal_level import dsal_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load_i,
  input  grade_t          grd_i,
  output logic [1:0]      level_o,
  output logic [1:0]      reason_o,
  output logic            on_o,
  output logic [CntW-1:0] count_o
);

  level_t          held_r;
  level_t          held_nxt;
  logic [CntW-1:0] act_r;
  logic [CntW-1:0] act_nxt;
  logic [1:0]      reason_r;
  logic            may_clr;

  always_comb begin
    case (held_r)
      LVL_CRITICAL: may_clr = grd_i.clr_critical;
      LVL_DANGER:   may_clr = grd_i.clr_danger;
      LVL_WARNING:  may_clr = grd_i.clr_warning;
      default:      may_clr = 1'b1;
    endcase
  end

  always_comb begin
    held_nxt = held_r;
    if (grd_i.cand > held_r) begin
      held_nxt = grd_i.cand;
    end else if ((grd_i.cand < held_r) && may_clr) begin
      held_nxt = grd_i.cand;
    end
    act_nxt = act_r;
    if ((held_r == LVL_NONE) && (held_nxt != LVL_NONE)) begin
      act_nxt = act_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= LVL_NONE;
      act_r  <= '0;
    end else if (load_i) begin
      held_r <= held_nxt;
      act_r  <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      reason_r <= grd_i.reason;
    end
  end

  assign level_o  = held_r;
  assign reason_o = reason_r;
  assign on_o     = (held_r != LVL_NONE);
  assign count_o  = act_r;

  `DSAL_ASSERT_NEXT(a_escalate, load_i && (grd_i.cand > held_r),
    held_r == $past(grd_i.cand), "higher candidate not taken at once")
  `DSAL_ASSERT_NEXT(a_count_rise, load_i && (held_r == LVL_NONE) && (grd_i.cand != LVL_NONE),
    act_r == $past(act_r) + 32'd1, "activation not counted")
  `DSAL_ASSERT_NEXT(a_count_hold, load_i && (held_r != LVL_NONE),
    act_r == $past(act_r), "count moved while alarm already on")
  `DSAL_ASSERT_NEXT(a_idle_hold, !load_i,
    $stable(held_r) && $stable(act_r), "state changed without an item")

endmodule

// ----- hw/rtl/dual_sensor_alarm_level_hysteresis.sv -----
// path: input register, then result register, from input accept to result valid
// throughput: one sample pair per cycle when not stalled, one level update per item
// reset: synchronous active low; clears the held level, the activation count
// and both valid flags, and loads the threshold registers with their defaults
// ----------------------------------------------------------------------------
// dual_sensor_alarm_level_hysteresis
// two-sensor multi-level alarm with per-level hysteresis and activation count
// ----------------------------------------------------------------------------
module dual_sensor_alarm_level_hysteresis import dsal_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [AqiW-1:0]     in_air_index,
  input  logic [Co2W-1:0]     in_co2_ppm,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_alarm_level,
  output logic [1:0]          out_alarm_reason,
  output logic                out_alarm_on,
  output logic [CntW-1:0]     out_activation_count
);

  thr_t            thr_r;
  logic            s1_valid_r;
  logic [AqiW-1:0] s1_aqi_r;
  logic [Co2W-1:0] s1_ppm_r;
  logic            out_valid_r;
  logic            s1_adv;
  logic            s1_load;
  grade_t          grd;

  // threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.aqi_warn_on  <= AqiWarnOnRst;
      thr_r.aqi_warn_off <= AqiWarnOffRst;
      thr_r.aqi_dang_on  <= AqiDangOnRst;
      thr_r.aqi_dang_off <= AqiDangOffRst;
      thr_r.aqi_crit_on  <= AqiCritOnRst;
      thr_r.aqi_crit_off <= AqiCritOffRst;
      thr_r.co2_warn     <= Co2WarnRst;
      thr_r.co2_dang     <= Co2DangRst;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_AQI_WARN_ON:  thr_r.aqi_warn_on  <= cfg_wdata[AqiW-1:0];
        REG_AQI_WARN_OFF: thr_r.aqi_warn_off <= cfg_wdata[AqiW-1:0];
        REG_AQI_DANG_ON:  thr_r.aqi_dang_on  <= cfg_wdata[AqiW-1:0];
        REG_AQI_DANG_OFF: thr_r.aqi_dang_off <= cfg_wdata[AqiW-1:0];
        REG_AQI_CRIT_ON:  thr_r.aqi_crit_on  <= cfg_wdata[AqiW-1:0];
        REG_AQI_CRIT_OFF: thr_r.aqi_crit_off <= cfg_wdata[AqiW-1:0];
        REG_CO2_WARN:     thr_r.co2_warn     <= cfg_wdata[Co2W-1:0];
        REG_CO2_DANG:     thr_r.co2_dang     <= cfg_wdata[Co2W-1:0];
        default:          thr_r <= thr_r;
      endcase
    end
  end

  // handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_aqi_r <= in_air_index;
      s1_ppm_r <= in_co2_ppm;
    end
  end

  dsal_grade u_grade (
    .thr_i (thr_r),
    .aqi_i (s1_aqi_r),
    .ppm_i (s1_ppm_r),
    .grd_o (grd)
  );

  dsal_level u_level (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_i   (s1_adv),
    .grd_i    (grd),
    .level_o  (out_alarm_level),
    .reason_o (out_alarm_reason),
    .on_o     (out_alarm_on),
    .count_o  (out_activation_count)
  );

  assign out_valid = out_valid_r;

endmodule
